>>> hdl/utf8_sanitizer_assert.svh
// assertion macros shared by the utf8 sanitizer modules
`ifndef UTF8_SANITIZER_ASSERT_SVH
`define UTF8_SANITIZER_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define UTF8S_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define UTF8S_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/utf8s_pkg.sv
// types, constants and helper functions of the utf8 sanitizer
package utf8s_pkg;

	// request payloads
	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_text;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_char;
		logic       run_last;
		logic       text_done;
	} out_item_t;

	// decision on the byte at the head of the buffer
	typedef logic [1:0] kind_t;
	localparam kind_t KIND_DONE = 2'd0;
	localparam kind_t KIND_ESC  = 2'd1;
	localparam kind_t KIND_SEQ  = 2'd2;

	// position inside a four-character escape
	typedef logic [1:0] esc_idx_t;
	localparam esc_idx_t ESC_SLASH = 2'd0;
	localparam esc_idx_t ESC_X     = 2'd1;
	localparam esc_idx_t ESC_HI    = 2'd2;
	localparam esc_idx_t ESC_LO    = 2'd3;

	localparam logic [7:0] CHAR_BSLASH = 8'h5C;
	localparam logic [7:0] CHAR_X      = 8'h78;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_LF     = 8'h0A;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_SPACE  = 8'h20;

	localparam logic [20:0] CP_MIN2      = 21'h00080;
	localparam logic [20:0] CP_MIN3      = 21'h00800;
	localparam logic [20:0] CP_MIN4      = 21'h10000;
	localparam logic [20:0] CP_MAX       = 21'h10FFFF;
	localparam logic [20:0] CP_SURR_LO   = 21'h0D800;
	localparam logic [20:0] CP_SURR_HI   = 21'h0DFFF;

	// controller to datapath
	typedef struct packed {
		logic     load;
		logic     shift;
		logic     esc_cap;
		logic     gen;
		logic     sel_esc;
		esc_idx_t esc_idx;
		logic     flush;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		kind_t      kind;
		logic [2:0] seq_len;
		logic       hold_v;
		logic       out_free;
	} dp_stat_t;

	// sequence length announced by a lead byte, zero if not a lead
	function automatic logic [2:0] lead_length(input logic [7:0] b);
		logic [2:0] len;
		len = 3'd0;
		if ((b & 8'hE0) == 8'hC0)
			len = 3'd2;
		else if ((b & 8'hF0) == 8'hE0)
			len = 3'd3;
		else if ((b & 8'hF8) == 8'hF0)
			len = 3'd4;
		return len;
	endfunction

	// upper-case hex digit of a nibble
	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] ch;
		if (v < 4'd10)
			ch = 8'h30 + {4'd0, v};
		else
			ch = 8'h41 + {4'd0, v} - 8'd10;
		return ch;
	endfunction

endpackage

>>> hdl/utf8s_dp.sv
// utf8 sanitizer datapath: byte buffer, decoder, character hold and output register
`include "utf8_sanitizer_assert.svh"
module utf8s_dp import utf8s_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  in_item_t  byte_data,
	input  dp_cmd_t   cmd,
	output dp_stat_t  stat,
	input  logic      char_stall,
	output logic      char_valid,
	output out_item_t char_data
);

	logic [7:0] buf_q [4];
	logic [2:0] cnt_q;
	logic       eot_q;
	logic [7:0] esc_q;
	logic [7:0] hold_q;
	logic       hold_v_q;
	logic       out_valid_q;
	out_item_t  out_q;

	logic [7:0]  lead;
	logic [2:0]  len;
	logic        cont_ok;
	logic        bad;
	logic        ascii_ok;
	logic [20:0] cp;
	logic [7:0]  esc_char;
	logic [7:0]  char_src;
	logic        out_free;
	logic        push;

	assign lead     = buf_q[0];
	assign len      = lead_length(lead);
	assign out_free = !out_valid_q || !char_stall;
	assign ascii_ok = (lead >= CHAR_SPACE) || (lead == CHAR_CR) || (lead == CHAR_LF)
		|| (lead == CHAR_TAB);

	// continuation bytes and gathered code point
	always_comb begin
		cont_ok = (buf_q[1][7:6] == 2'b10)
			&& ((len < 3'd3) || (buf_q[2][7:6] == 2'b10))
			&& ((len < 3'd4) || (buf_q[3][7:6] == 2'b10));
		unique case (len)
			3'd2:    cp = {10'd0, lead[4:0], buf_q[1][5:0]};
			3'd3:    cp = {5'd0, lead[3:0], buf_q[1][5:0], buf_q[2][5:0]};
			3'd4:    cp = {lead[2:0], buf_q[1][5:0], buf_q[2][5:0], buf_q[3][5:0]};
			default: cp = 21'd0;
		endcase
		bad = !cont_ok
			|| ((len == 3'd2) && (cp < CP_MIN2))
			|| ((len == 3'd3) && (cp < CP_MIN3))
			|| ((len == 3'd4) && (cp < CP_MIN4))
			|| (cp > CP_MAX)
			|| ((cp >= CP_SURR_LO) && (cp <= CP_SURR_HI));
	end

	// decision on the head byte
	always_comb begin
		stat.seq_len = 3'd1;
		priority if (cnt_q == 3'd0) begin
			stat.kind = KIND_DONE;
		end else if (!lead[7]) begin
			stat.kind = ascii_ok ? KIND_SEQ : KIND_ESC;
		end else if (len == 3'd0) begin
			stat.kind = KIND_ESC;
		end else if (len > cnt_q) begin
			stat.kind = eot_q ? KIND_ESC : KIND_DONE;
		end else begin
			stat.kind    = bad ? KIND_ESC : KIND_SEQ;
			stat.seq_len = len;
		end
		stat.hold_v   = hold_v_q;
		stat.out_free = out_free;
	end

	// character source for the hold register
	always_comb begin
		unique case (cmd.esc_idx)
			ESC_SLASH: esc_char = CHAR_BSLASH;
			ESC_X:     esc_char = CHAR_X;
			ESC_HI:    esc_char = hex_digit(esc_q[7:4]);
			ESC_LO:    esc_char = hex_digit(esc_q[3:0]);
			default:   esc_char = CHAR_BSLASH;
		endcase
		char_src = cmd.sel_esc ? esc_char : lead;
	end

	assign push = (cmd.gen && hold_v_q) || cmd.flush;

	// byte buffer, escape capture, hold and output data, payload only
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			buf_q[cnt_q[1:0]] <= byte_data.data_byte;
			eot_q             <= byte_data.end_of_text;
		end else if (cmd.shift) begin
			buf_q[0] <= buf_q[1];
			buf_q[1] <= buf_q[2];
			buf_q[2] <= buf_q[3];
		end
		if (cmd.esc_cap)
			esc_q <= lead;
		if (cmd.gen)
			hold_q <= char_src;
		if (cmd.gen && hold_v_q)
			out_q <= '{out_char: hold_q, run_last: 1'b0, text_done: 1'b0};
		else if (cmd.flush)
			out_q <= '{out_char: hold_q, run_last: 1'b1, text_done: eot_q};
	end

	// buffer fill count and valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= 3'd0;
			hold_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.load)
				cnt_q <= cnt_q + 3'd1;
			else if (cmd.shift)
				cnt_q <= cnt_q - 3'd1;
			if (cmd.gen)
				hold_v_q <= 1'b1;
			else if (cmd.flush)
				hold_v_q <= 1'b0;
			if (push)
				out_valid_q <= 1'b1;
			else if (!char_stall)
				out_valid_q <= 1'b0;
		end
	end

	assign char_valid = out_valid_q;
	assign char_data  = out_q;

	`UTF8S_ASSERT_NOW(a_cnt_range, clk, arst_n, 1'b1, cnt_q <= 3'd4, "buffer count above four")
	`UTF8S_ASSERT_NOW(a_load_room, clk, arst_n, cmd.load, cnt_q <= 3'd3, "request loaded into full buffer")
	`UTF8S_ASSERT_NOW(a_push_room, clk, arst_n, push, out_free, "output register overwritten")

endmodule

>>> hdl/utf8s_ctrl.sv
// utf8 sanitizer controller: scan, escape and sequence emission state machine
`include "utf8_sanitizer_assert.svh"
module utf8s_ctrl import utf8s_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     byte_valid,
	output logic     byte_stall,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_EVAL  = 3'd1;
	localparam logic [2:0] S_ESC   = 3'd2;
	localparam logic [2:0] S_SEQ   = 3'd3;
	localparam logic [2:0] S_FLUSH = 3'd4;

	logic [2:0] state_q, state_d;
	esc_idx_t   idx_q, idx_d;
	logic [2:0] rem_q, rem_d;
	logic       adv;

	// a character may enter the hold when the hold is empty or can drain
	assign adv        = !stat.hold_v || stat.out_free;
	assign byte_stall = (state_q != S_IDLE);

	// next state and commands
	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		rem_d       = rem_q;
		cmd         = '0;
		cmd.esc_idx = idx_q;
		unique case (state_q)
			S_IDLE: begin
				if (byte_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EVAL;
				end
			end
			S_EVAL: begin
				unique case (stat.kind)
					KIND_ESC: begin
						cmd.esc_cap = 1'b1;
						cmd.shift   = 1'b1;
						idx_d       = ESC_SLASH;
						state_d     = S_ESC;
					end
					KIND_SEQ: begin
						rem_d   = stat.seq_len;
						state_d = S_SEQ;
					end
					default: begin
						state_d = stat.hold_v ? S_FLUSH : S_IDLE;
					end
				endcase
			end
			S_ESC: begin
				cmd.sel_esc = 1'b1;
				if (adv) begin
					cmd.gen = 1'b1;
					idx_d   = idx_q + 2'd1;
					if (idx_q == ESC_LO)
						state_d = S_EVAL;
				end
			end
			S_SEQ: begin
				if (adv) begin
					cmd.gen   = 1'b1;
					cmd.shift = 1'b1;
					rem_d     = rem_q - 3'd1;
					if (rem_q == 3'd1)
						state_d = S_EVAL;
				end
			end
			S_FLUSH: begin
				if (stat.out_free) begin
					cmd.flush = 1'b1;
					state_d   = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= ESC_SLASH;
			rem_q   <= 3'd0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			rem_q   <= rem_d;
		end
	end

	`UTF8S_ASSERT_NOW(a_flush_hold, clk, arst_n, state_q == S_FLUSH, stat.hold_v, "flush with empty hold")
	`UTF8S_ASSERT_NOW(a_seq_rem, clk, arst_n, state_q == S_SEQ, rem_q != 3'd0, "sequence with zero bytes left")
	`UTF8S_ASSERT_NEXT(a_eval_after_load, clk, arst_n, cmd.load, state_q == S_EVAL, "load not followed by scan")

endmodule

>>> hdl/utf8_sanitizer.sv
// utf8 sanitizer top level: byte request in, sanitized character requests out
// a character waits in the hold until the next one enters it or, for the last of a request, the flush
// byte_stall is raised whenever the controller leaves idle, so a new byte request
//   is taken only after the serial scan and hold path have finished the last one
// an escape emits four characters, a passed sequence one character per byte
// reset: arst_n clears the buffer count, state and valid flags; buffer data is not reset
module utf8_sanitizer import utf8s_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      byte_valid,
	output logic      byte_stall,
	input  in_item_t  byte_data,
	output logic      char_valid,
	input  logic      char_stall,
	output out_item_t char_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// controller
	utf8s_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.stat       (stat),
		.cmd        (cmd)
	);

	// datapath
	utf8s_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_data  (byte_data),
		.cmd        (cmd),
		.stat       (stat),
		.char_stall (char_stall),
		.char_valid (char_valid),
		.char_data  (char_data)
	);

endmodule

>>> bench/utf8_sanitizer_tb.sv
// self-checking testbench of the utf8 sanitizer with queued stimulus and a character predictor
module utf8_sanitizer_tb import utf8s_pkg::*; ();

	localparam int RANDOM_BYTES   = 425;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int DRAIN_CYCLES   = 24;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      byte_valid = 1'b0;
	logic      byte_stall;
	in_item_t  byte_data = '0;
	logic      char_valid;
	logic      char_stall = 1'b0;
	out_item_t char_data;

	// stimulus and expectation stores
	in_item_t  pending_reqs[$];
	out_item_t expected_chars[$];
	logic [7:0] text_bytes[$];
	logic [7:0] glyph[$];

	// predictor state: bytes of an unfinished sequence, lead first
	logic [7:0] held_bytes [3];
	int         held_count = 0;

	logic in_took = 1'b0;
	int   gap_left = 0;
	int   calm_items = 0;
	int   stall_left = 0;
	int   sink_calm = 0;
	int   idle_cycles = 0;
	int   mismatches = 0;
	int   reqs_taken = 0;
	int   chars_checked = 0;
	int   texts_sent = 0;

	utf8_sanitizer DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_data  (byte_data),
		.char_valid (char_valid),
		.char_stall (char_stall),
		.char_data  (char_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// idle length: mostly none or short, a few long
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// length announced by a lead byte, zero for anything else
	function automatic int announced_length(input logic [7:0] b);
		if ((b & 8'hE0) == 8'hC0)
			return 2;
		if ((b & 8'hF0) == 8'hE0)
			return 3;
		if ((b & 8'hF8) == 8'hF0)
			return 4;
		return 0;
	endfunction

	function automatic logic [7:0] nibble_char(input logic [3:0] v);
		if (v < 4'd10)
			return 8'h30 + {4'd0, v};
		return 8'h41 + {4'd0, v} - 8'd10;
	endfunction

	task automatic push_char(input logic [7:0] ch);
		out_item_t e;
		e.out_char  = ch;
		e.run_last  = 1'b0;
		e.text_done = 1'b0;
		expected_chars.insert(expected_chars.size(), e);
	endtask

	task automatic push_escape(input logic [7:0] b);
		push_char(CHAR_BSLASH);
		push_char(CHAR_X);
		push_char(nibble_char(b[7:4]));
		push_char(nibble_char(b[3:0]));
	endtask

	// expected characters caused by one accepted byte request
	task automatic sanitize_request(input in_item_t req);
		logic [7:0] work_bytes [4];
		logic [7:0] b;
		logic [7:0] c;
		logic [20:0] cp;
		logic        ok;
		logic        waiting;
		int          n;
		int          p;
		int          len;
		int          first;
		out_item_t   tail;
		n = 0;
		p = 0;
		waiting = 1'b0;
		first = expected_chars.size();
		for (int i = 0; i < held_count; i++) begin
			work_bytes[n] = held_bytes[i];
			n++;
		end
		work_bytes[n] = req.data_byte;
		n++;
		while (p < n && !waiting) begin
			b = work_bytes[p];
			len = announced_length(b);
			if (b <= 8'h7F) begin
				// ascii: bytes below space other than tab, lf and cr are escaped
				if (b >= CHAR_SPACE || b == CHAR_CR || b == CHAR_LF || b == CHAR_TAB)
					push_char(b);
				else
					push_escape(b);
				p++;
			end else if (len == 0) begin
				// stray continuation or byte that never leads
				push_escape(b);
				p++;
			end else if (p + len > n) begin
				// sequence not complete: wait, or escape the lead at end of text
				if (!req.end_of_text) begin
					waiting = 1'b1;
				end else begin
					push_escape(b);
					p++;
				end
			end else begin
				ok = 1'b1;
				case (len)
					2: cp = {16'd0, b[4:0]};
					3: cp = {17'd0, b[3:0]};
					default: cp = {18'd0, b[2:0]};
				endcase
				for (int i = 1; i < len; i++) begin
					c = work_bytes[p + i];
					if ((c & 8'hC0) != 8'h80)
						ok = 1'b0;
					cp = {cp[14:0], c[5:0]};
				end
				// bad continuation, overlong, out of range or surrogate
				if (!ok || (len == 2 && cp < CP_MIN2) || (len == 3 && cp < CP_MIN3)
					|| (len == 4 && cp < CP_MIN4) || cp > CP_MAX
					|| (cp >= CP_SURR_LO && cp <= CP_SURR_HI)) begin
					push_escape(b);
					p++;
				end else begin
					for (int i = 0; i < len; i++)
						push_char(work_bytes[p + i]);
					p += len;
				end
			end
		end
		// keep the unfinished remainder for the next request
		held_count = 0;
		while (p < n) begin
			held_bytes[held_count] = work_bytes[p];
			held_count++;
			p++;
		end
		if (expected_chars.size() > first) begin
			tail = expected_chars.pop_back();
			tail.run_last  = 1'b1;
			tail.text_done = req.end_of_text;
			expected_chars.insert(expected_chars.size(), tail);
		end
	endtask

	task automatic report_mismatch(input string what, input logic [7:0] got,
		input logic [7:0] want);
		mismatches++;
		$display("char %0d: %s got %02h want %02h", chars_checked, what, got, want);
	endtask

	task automatic queue_req(input logic [7:0] b, input logic eot);
		in_item_t it;
		it.data_byte   = b;
		it.end_of_text = eot;
		pending_reqs.insert(pending_reqs.size(), it);
	endtask

	// encode a code point in a given number of bytes, range not checked
	task automatic encode_cp(input logic [20:0] cp, input int len);
		glyph.delete();
		case (len)
			1: glyph.insert(glyph.size(), cp[7:0]);
			2: begin
				glyph.insert(glyph.size(), {3'b110, cp[10:6]});
				glyph.insert(glyph.size(), {2'b10, cp[5:0]});
			end
			3: begin
				glyph.insert(glyph.size(), {4'b1110, cp[15:12]});
				glyph.insert(glyph.size(), {2'b10, cp[11:6]});
				glyph.insert(glyph.size(), {2'b10, cp[5:0]});
			end
			default: begin
				glyph.insert(glyph.size(), {5'b11110, cp[20:18]});
				glyph.insert(glyph.size(), {2'b10, cp[17:12]});
				glyph.insert(glyph.size(), {2'b10, cp[11:6]});
				glyph.insert(glyph.size(), {2'b10, cp[5:0]});
			end
		endcase
	endtask

	task automatic make_valid(input int len);
		logic [20:0] cp;
		case (len)
			2: cp = 21'($urandom_range(32'h80, 32'h7FF));
			3: begin
				cp = 21'($urandom_range(32'h800, 32'hFFFF));
				if (cp >= CP_SURR_LO && cp <= CP_SURR_HI)
					cp = cp - 21'h800;
			end
			default: cp = 21'($urandom_range(32'h10000, 32'h10FFFF));
		endcase
		encode_cp(cp, len);
	endtask

	task automatic make_truncated();
		int len;
		len = $urandom_range(2, 4);
		make_valid(len);
		repeat ($urandom_range(1, len - 1))
			void'(glyph.pop_back());
	endtask

	// one character of random text, mostly well formed
	task automatic add_glyph();
		int r;
		int len;
		int k;
		logic [7:0] c;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			encode_cp(21'($urandom_range(32, 126)), 1);
		end else if (r < 35) begin
			c = 8'($urandom_range(0, 32));
			encode_cp((c == 8'd32) ? 21'h7F : {13'd0, c}, 1);
		end else if (r < 50) begin
			make_valid(2);
		end else if (r < 63) begin
			make_valid(3);
		end else if (r < 73) begin
			make_valid(4);
		end else if (r < 76) begin
			// overlong form
			len = $urandom_range(2, 4);
			case (len)
				2: encode_cp(21'($urandom_range(0, 32'h7F)), 2);
				3: encode_cp(21'($urandom_range(0, 32'h7FF)), 3);
				default: encode_cp(21'($urandom_range(0, 32'hFFFF)), 4);
			endcase
		end else if (r < 79) begin
			encode_cp(21'($urandom_range(32'hD800, 32'hDFFF)), 3);
		end else if (r < 82) begin
			encode_cp(21'($urandom_range(32'h110000, 32'h1FFFFF)), 4);
		end else if (r < 87) begin
			glyph.delete();
			if ($urandom_range(0, 1))
				glyph.insert(glyph.size(), 8'($urandom_range(32'h80, 32'hBF)));
			else
				glyph.insert(glyph.size(), 8'($urandom_range(32'hF8, 32'hFF)));
		end else if (r < 93) begin
			make_truncated();
		end else if (r < 97) begin
			// one continuation replaced by a byte that does not continue
			len = $urandom_range(2, 4);
			make_valid(len);
			k = $urandom_range(1, len - 1);
			c = 8'($urandom);
			if ((c & 8'hC0) == 8'h80)
				c = c ^ (($urandom_range(0, 1)) ? 8'h40 : 8'h80);
			glyph[k] = c;
		end else begin
			glyph.delete();
			glyph.insert(glyph.size(), 8'($urandom));
		end
		foreach (glyph[i])
			text_bytes.insert(text_bytes.size(), glyph[i]);
	endtask

	// stimulus, reset and end of run
	initial begin
		logic [7:0] directed_bytes [25];
		int random_bytes;
		int n_chars;
		directed_bytes = '{8'h00, 8'h09, 8'h0A, 8'h0D, 8'h20, 8'h7F, 8'h80, 8'hFF,
			8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF0, 8'h9F, 8'h98, 8'h80,
			8'hF4, 8'h90, 8'h80, 8'h80, 8'hC3, 8'h41, 8'hE2, 8'h82};
		// directed text, cut short on its last byte
		foreach (directed_bytes[i])
			queue_req(directed_bytes[i], i == 24);
		texts_sent = 1;
		// random texts, each closed by end of text
		random_bytes = 0;
		while (random_bytes < RANDOM_BYTES) begin
			n_chars = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
			text_bytes.delete();
			repeat (n_chars)
				add_glyph();
			if ($urandom_range(0, 4) == 0) begin
				make_truncated();
				foreach (glyph[i])
					text_bytes.insert(text_bytes.size(), glyph[i]);
			end
			foreach (text_bytes[i])
				queue_req(text_bytes[i], i == text_bytes.size() - 1);
			random_bytes += text_bytes.size();
			texts_sent++;
		end
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		while (pending_reqs.size() > 0 || byte_valid || expected_chars.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("sent %0d byte requests in %0d texts, checked %0d output characters",
			reqs_taken, texts_sent, chars_checked);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// byte request driver with random gaps and calm stretches
	always @(negedge clk) begin
		logic     nxt_valid;
		in_item_t nxt_data;
		if (arst_n) begin
			nxt_valid = byte_valid;
			nxt_data = byte_data;
			if (byte_valid && in_took)
				nxt_valid = 1'b0;
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_reqs.size() > 0) begin
					nxt_data = pending_reqs.pop_front();
					nxt_valid = 1'b1;
					if (calm_items == 0 && $urandom_range(0, 99) < 3)
						calm_items = $urandom_range(20, 80);
					if (calm_items > 0) begin
						calm_items--;
						gap_left = 0;
					end else begin
						gap_left = pick_idle();
					end
				end
			end
			byte_valid <= nxt_valid;
			byte_data <= nxt_data;
		end
	end

	// character stall pattern
	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				char_stall <= 1'b1;
			end else if (sink_calm > 0) begin
				sink_calm--;
				char_stall <= 1'b0;
			end else if ($urandom_range(0, 99) < 2) begin
				sink_calm = $urandom_range(30, 150);
				char_stall <= 1'b0;
			end else begin
				stall_left = pick_idle();
				char_stall <= (stall_left > 0);
				if (stall_left > 0)
					stall_left--;
			end
		end
	end

	// monitor: predict on byte accept, check on character accept, watchdog
	always @(posedge clk) begin
		out_item_t want;
		if (arst_n) begin
			in_took <= byte_valid && !byte_stall;
			if (byte_valid && !byte_stall) begin
				sanitize_request(byte_data);
				reqs_taken++;
			end
			if (char_valid && !char_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("unexpected char", char_data.out_char, 8'h00);
				end else begin
					want = expected_chars.pop_front();
					if (char_data.out_char !== want.out_char)
						report_mismatch("out_char", char_data.out_char, want.out_char);
					if (char_data.run_last !== want.run_last)
						report_mismatch("run_last", {7'd0, char_data.run_last},
							{7'd0, want.run_last});
					if (char_data.text_done !== want.text_done)
						report_mismatch("text_done", {7'd0, char_data.text_done},
							{7'd0, want.text_done});
				end
				chars_checked++;
			end
			if ((byte_valid && !byte_stall) || (char_valid && !char_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles", idle_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

endmodule
